// ===== hdl/thk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package thk_pkg;

  localparam int NUM_KEYS = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_DELAY      = 2'd2;

  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd40;
  localparam logic [7:0] BLINK_TICKS_RST      = 8'd10;
  localparam logic [7:0] FAULT_DELAY_RST      = 8'd15;
  localparam logic [7:0] BLINK_FIRST_RST      = 8'(2 * 10);

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  typedef struct packed {
    logic [NUM_KEYS-1:0] key_levels;
    logic                fault_line;
    logic [NUM_KEYS-1:0] clear_presses;
  } in_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] keys_down;
    logic [NUM_KEYS-1:0] keys_held;
    logic [NUM_KEYS-1:0] keys_pressed;
    logic [NUM_KEYS-1:0] keys_released;
    logic                blink;
    logic                blink_update;
    logic                second_pulse;
    logic                fault;
    logic [5:0]          seconds;
    logic [5:0]          minutes;
    logic [4:0]          hours;
  } out_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] down;
    logic [NUM_KEYS-1:0] held;
    logic [NUM_KEYS-1:0] pressed;
    logic [NUM_KEYS-1:0] released;
  } key_stat_t;

  typedef struct packed {
    logic blink;
    logic blink_update;
    logic second_pulse;
  } tb_stat_t;

  typedef struct packed {
    logic       fault;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
  } clk_stat_t;

endpackage

`default_nettype wire

// ===== hdl/thk_keys.sv =====
`timescale 1ns / 1ps
`default_nettype none

module thk_keys (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        tick,
  input  wire logic [thk_pkg::NUM_KEYS-1:0] key_levels,
  input  wire logic [thk_pkg::NUM_KEYS-1:0] clear_presses,
  output thk_pkg::key_stat_t               stat
);
  import thk_pkg::*;

  logic [NUM_KEYS-1:0] prev_r, down_r, held_r, press_r;
  logic [NUM_KEYS-1:0] down_nxt, held_nxt, press_nxt, released;

  always_comb begin
    released  = down_r & key_levels;
    held_nxt  = down_r & ~key_levels;
    // down needs the key low on this sample and the one before
    down_nxt  = ~prev_r & ~key_levels;
    // clear first, so a press seen on the same tick survives
    press_nxt = (press_r & ~clear_presses) | (down_nxt & ~held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '1;
      down_r  <= '0;
      held_r  <= '0;
      press_r <= '0;
    end else if (tick) begin
      prev_r  <= key_levels;
      down_r  <= down_nxt;
      held_r  <= held_nxt;
      press_r <= press_nxt;
    end
  end

  assign stat.down     = down_nxt;
  assign stat.held     = held_nxt;
  assign stat.pressed  = press_nxt;
  assign stat.released = released;

endmodule

`default_nettype wire

// ===== hdl/thk_timebase.sv =====
`timescale 1ns / 1ps
`default_nettype none

module thk_timebase (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       tick,
  input  wire logic [7:0] ticks_per_second,
  input  wire logic [7:0] blink_ticks,
  output thk_pkg::tb_stat_t stat
);
  import thk_pkg::*;

  logic [7:0] blink_cnt_r, blink_cnt_nxt, sec_div_r, sec_div_nxt;
  logic [7:0] blink_dec, sec_dec;
  logic       blink_r, blink_nxt;
  logic       blink_upd, sec_pulse;

  always_comb begin
    // a zero reload wraps to 255 on the next decrement
    blink_dec     = blink_cnt_r - 8'd1;
    blink_upd     = (blink_dec == 8'd0);
    blink_cnt_nxt = blink_upd ? blink_ticks : blink_dec;
    blink_nxt     = blink_r ^ blink_upd;

    sec_dec     = sec_div_r - 8'd1;
    sec_pulse   = (sec_dec == 8'd0);
    sec_div_nxt = sec_pulse ? ticks_per_second : sec_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_cnt_r <= BLINK_FIRST_RST;
      blink_r     <= 1'b0;
      sec_div_r   <= TICKS_PER_SECOND_RST;
    end else if (tick) begin
      blink_cnt_r <= blink_cnt_nxt;
      blink_r     <= blink_nxt;
      sec_div_r   <= sec_div_nxt;
    end
  end

  assign stat.blink        = blink_nxt;
  assign stat.blink_update = blink_upd;
  assign stat.second_pulse = sec_pulse;

endmodule

`default_nettype wire

// ===== hdl/thk_fault_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none

module thk_fault_clock (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       second,
  input  wire logic       fault_line,
  input  wire logic [7:0] fault_delay,
  output thk_pkg::clk_stat_t stat
);
  import thk_pkg::*;

  logic [7:0] high_r, high_nxt, low_r, low_nxt;
  logic       fault_r, fault_nxt;
  logic [5:0] sec_r, sec_nxt, min_r, min_nxt;
  logic [4:0] hour_r, hour_nxt;

  always_comb begin
    high_nxt  = high_r;
    low_nxt   = low_r;
    fault_nxt = fault_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    if (second) begin
      // each level restarts the opposite timer and runs its own down
      if (fault_line) begin
        low_nxt  = fault_delay;
        high_nxt = (high_r != 8'd0) ? high_r - 8'd1 : 8'd0;
      end else begin
        high_nxt = fault_delay;
        low_nxt  = (low_r != 8'd0) ? low_r - 8'd1 : 8'd0;
      end
      if (!fault_r && high_nxt == 8'd0) begin
        fault_nxt = 1'b1;
      end else if (fault_r && low_nxt == 8'd0) begin
        fault_nxt = 1'b0;
      end

      if (sec_r >= SEC_MAX) begin
        sec_nxt = '0;
        if (min_r >= MIN_MAX) begin
          min_nxt  = '0;
          hour_nxt = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
        end else begin
          min_nxt = min_r + 6'd1;
        end
      end else begin
        sec_nxt = sec_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r  <= FAULT_DELAY_RST;
      low_r   <= FAULT_DELAY_RST;
      fault_r <= 1'b0;
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
    end else begin
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      fault_r <= fault_nxt;
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
    end
  end

  assign stat.fault   = fault_nxt;
  assign stat.seconds = sec_nxt;
  assign stat.minutes = min_nxt;
  assign stat.hours   = hour_nxt;

endmodule

`default_nettype wire

// ===== hdl/tick_housekeeping_keys_fault_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick housekeeping: each input transaction is one 25 ms tick and yields exactly
// one result transaction (debounced keys, press latches, blink phase, second
// pulse, qualified fault flag and the hh:mm:ss clock, all as after that tick).
// Every counter and flag is updated in a single pass from its own register, and
// the result is registered when the input is taken, into the output register or,
// while that register is held, into the skid entry. A two-entry output buffer sits
// in front of the result port, so one tick per cycle is sustained while out_stall
// is low and in_stall rises only once both entries hold untaken results.
// Register writes are always accepted and take effect at the next reload of the
// counter they feed; write them only while no tick is in flight.
module tick_housekeeping_keys_fault_clock (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire thk_pkg::in_t                    in_data,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      thk_pkg::out_t                   out_data,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [thk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                      cfg_data
);
  import thk_pkg::*;

  logic [7:0] tps_r, blink_ticks_r, fault_delay_r;
  logic       accept, out_take;
  key_stat_t  key_stat;
  tb_stat_t   tb_stat;
  clk_stat_t  clk_stat;
  out_t       res;
  out_t       out_r, skid_r;
  logic       out_valid_r, skid_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r         <= TICKS_PER_SECOND_RST;
      blink_ticks_r <= BLINK_TICKS_RST;
      fault_delay_r <= FAULT_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_r         <= cfg_data;
        CFG_BLINK_TICKS:      blink_ticks_r <= cfg_data;
        CFG_FAULT_DELAY:      fault_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  thk_keys u_keys (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (accept),
    .key_levels    (in_data.key_levels),
    .clear_presses (in_data.clear_presses),
    .stat          (key_stat)
  );

  thk_timebase u_timebase (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick             (accept),
    .ticks_per_second (tps_r),
    .blink_ticks      (blink_ticks_r),
    .stat             (tb_stat)
  );

  thk_fault_clock u_fault_clock (
    .clk         (clk),
    .rst_n       (rst_n),
    .second      (accept && tb_stat.second_pulse),
    .fault_line  (in_data.fault_line),
    .fault_delay (fault_delay_r),
    .stat        (clk_stat)
  );

  always_comb begin
    res.keys_down     = key_stat.down;
    res.keys_held     = key_stat.held;
    res.keys_pressed  = key_stat.pressed;
    res.keys_released = key_stat.released;
    res.blink         = tb_stat.blink;
    res.blink_update  = tb_stat.blink_update;
    res.second_pulse  = tb_stat.second_pulse;
    res.fault         = clk_stat.fault;
    res.seconds       = clk_stat.seconds;
    res.minutes       = clk_stat.minutes;
    res.hours         = clk_stat.hours;
  end

  // output register plus one skid entry; the skid drains first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (out_valid_r && !out_take && accept) begin
      skid_r <= res;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
